@@ src/periodic_task_tick_scheduler_assert.svh @@
// Assertion macros used by the checker of the tick scheduler.
`ifndef PERIODIC_TASK_TICK_SCHEDULER_ASSERT_SVH
`define PERIODIC_TASK_TICK_SCHEDULER_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while reset is low.
`define PTTS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tick scheduler port check failed");

// Next-cycle implication, sampled on i_clk, off while reset is low.
`define PTTS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tick scheduler port check failed");

`endif

@@ src/ptts_pkg.sv @@
package ptts_pkg;

    localparam int ID_W   = 8;
    localparam int PER_W  = 16;
    localparam int CNT_W  = 4;
    localparam int KIND_W = 3;

    // Id value that marks a free slot.
    localparam logic [ID_W-1:0] INACTIVE_ID = 8'hFF;

    // Requested operation.
    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_SCHED = 2'd1,
        OP_DESCH = 2'd2,
        OP_PROC  = 2'd3
    } t_op;

    // Result kind.
    typedef enum logic [KIND_W-1:0] {
        KIND_SCHED    = 3'd0,
        KIND_DESCH    = 3'd1,
        KIND_TICK     = 3'd2,
        KIND_DISPATCH = 3'd3,
        KIND_IDLE     = 3'd4
    } t_kind;

    // Token that walks the slot chain.
    typedef struct packed {
        t_op              op;
        logic [ID_W-1:0]  id;
        logic [PER_W-1:0] period;
        logic             found;
        logic [CNT_W-1:0] queued;
        logic [CNT_W-1:0] dropped;
    } t_pkt;

    // Events a slot raises while it holds the token.
    typedef struct packed {
        logic push;
        logic disp;
    } t_cell_evt;

    // Due ring status.
    typedef struct packed {
        logic full;
        logic empty;
    } t_ring_stat;

endpackage

@@ src/ptts_cell.sv @@
module ptts_cell (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_adv,
    input  logic                               i_ring_full,
    input  logic                               i_tok,
    input  ptts_pkg::t_pkt                     i_pkt,
    output logic                               o_tok,
    output ptts_pkg::t_pkt                     o_pkt,
    output ptts_pkg::t_cell_evt                o_evt,
    output logic [ptts_pkg::ID_W-1:0]          o_id
);

    logic [ptts_pkg::ID_W-1:0]  r_id;
    logic [ptts_pkg::ID_W-1:0]  n_id;
    logic [ptts_pkg::PER_W-1:0] r_period;
    logic [ptts_pkg::PER_W-1:0] n_period;
    logic [ptts_pkg::PER_W-1:0] r_counter;
    logic [ptts_pkg::PER_W-1:0] n_counter;
    logic                       r_tok;
    ptts_pkg::t_pkt             r_pkt;
    ptts_pkg::t_pkt             n_pkt;
    logic                       w_active;

    assign w_active = (r_id != ptts_pkg::INACTIVE_ID);

    // Apply the token's operation to this slot
    always_comb begin
        n_id      = r_id;
        n_period  = r_period;
        n_counter = r_counter;
        n_pkt     = i_pkt;
        o_evt     = '0;
        if (i_tok) begin
            unique case (i_pkt.op)
                ptts_pkg::OP_TICK: begin
                    if (w_active && (r_period != '0)) begin
                        if (r_counter == r_period) begin
                            n_counter = ptts_pkg::PER_W'(1);
                            if (!i_ring_full) begin
                                o_evt.push   = 1'b1;
                                n_pkt.queued = i_pkt.queued + ptts_pkg::CNT_W'(1);
                            end else begin
                                n_pkt.dropped = i_pkt.dropped + ptts_pkg::CNT_W'(1);
                            end
                        end else begin
                            n_counter = r_counter + ptts_pkg::PER_W'(1);
                        end
                    end
                end
                ptts_pkg::OP_SCHED: begin
                    if (!w_active && !i_pkt.found && (i_pkt.id != ptts_pkg::INACTIVE_ID)) begin
                        n_id        = i_pkt.id;
                        n_period    = i_pkt.period;
                        n_counter   = ptts_pkg::PER_W'(1);
                        n_pkt.found = 1'b1;
                    end
                end
                ptts_pkg::OP_DESCH: begin
                    if ((i_pkt.id != ptts_pkg::INACTIVE_ID) && (r_id == i_pkt.id)) begin
                        n_id = ptts_pkg::INACTIVE_ID;
                    end
                end
                ptts_pkg::OP_PROC: begin
                    o_evt.disp = w_active && (r_period == '0);
                end
            endcase
        end
    end

    // Control: slot id and token valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id  <= ptts_pkg::INACTIVE_ID;
            r_tok <= 1'b0;
        end else if (i_adv) begin
            r_id  <= n_id;
            r_tok <= i_tok;
        end
    end

    // Payload: period, counter and the token handed to the neighbor
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_period  <= n_period;
            r_counter <= n_counter;
            r_pkt     <= n_pkt;
        end
    end

    assign o_tok = r_tok;
    assign o_pkt = r_pkt;
    assign o_id  = r_id;

endmodule

@@ src/ptts_ring.sv @@
module ptts_ring #(
    parameter int DEPTH  = 16,
    parameter int DATA_W = 3
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [DATA_W-1:0]    i_push_data,
    input  logic                 i_pop,
    output ptts_pkg::t_ring_stat o_stat,
    output logic [DATA_W-1:0]    o_rd_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;
    logic [AW-1:0]     r_wptr;
    logic [AW-1:0]     n_wptr;
    logic [AW-1:0]     r_rptr;
    logic [AW-1:0]     n_rptr;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;

    // Advance pointers with wrap at the ring depth
    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr  = (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);
            n_count = r_count + CW'(1);
        end else if (i_pop) begin
            n_rptr  = (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + AW'(1);
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Storage: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_push_data;
        end
        if (i_pop) begin
            r_rd_data <= r_mem[r_rptr];
        end
    end

    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_rd_data    = r_rd_data;

endmodule

@@ src/periodic_task_tick_scheduler.sv @@
// Tick, schedule and deschedule: one reply, once the token has walked the whole row of slot cells.
// Process: drain the due ring one entry at a time (read, then check), then walk the row for immediate tasks.
// One input at a time; the next is taken once the final result sits in the output register.
// The token walks the row of slot cells one cell per cycle while the output register can take a result.
// Reset (i_rst_n low, synchronous): all slots inactive, ring empty, no result pending.
module periodic_task_tick_scheduler #(
    parameter int SLOTS      = 8,
    parameter int RING_DEPTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [1:0]                        i_mode,
    input  logic [ptts_pkg::ID_W-1:0]         i_task_id,
    input  logic [ptts_pkg::PER_W-1:0]        i_period,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [ptts_pkg::KIND_W-1:0]       o_kind,
    output logic [ptts_pkg::ID_W-1:0]         o_task_id_res,
    output logic                              o_accepted,
    output logic [ptts_pkg::CNT_W-1:0]        o_queued,
    output logic [ptts_pkg::CNT_W-1:0]        o_dropped,
    output logic                              o_last
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_POP_RD  = 4'b0010,
        S_POP_CHK = 4'b0100,
        S_WALK    = 4'b1000
    } t_state;

    t_state                      r_state;
    t_state                      n_state;
    ptts_pkg::t_op               r_op;
    ptts_pkg::t_op               n_op;
    logic [ptts_pkg::ID_W-1:0]   r_id;
    logic [ptts_pkg::ID_W-1:0]   n_id;
    logic [ptts_pkg::PER_W-1:0]  r_period;
    logic [ptts_pkg::PER_W-1:0]  n_period;
    logic                        r_launch;
    logic                        n_launch;
    logic                        r_hold_valid;
    logic                        n_hold_valid;
    logic [ptts_pkg::ID_W-1:0]   r_hold_id;
    logic [ptts_pkg::ID_W-1:0]   n_hold_id;
    logic                        r_out_valid;
    logic                        n_out_valid;
    ptts_pkg::t_kind             r_out_kind;
    ptts_pkg::t_kind             n_out_kind;
    logic [ptts_pkg::ID_W-1:0]   r_out_id;
    logic [ptts_pkg::ID_W-1:0]   n_out_id;
    logic                        r_out_acc;
    logic                        n_out_acc;
    logic [ptts_pkg::CNT_W-1:0]  r_out_q;
    logic [ptts_pkg::CNT_W-1:0]  n_out_q;
    logic [ptts_pkg::CNT_W-1:0]  r_out_d;
    logic [ptts_pkg::CNT_W-1:0]  n_out_d;
    logic                        r_out_last;
    logic                        n_out_last;

    logic                        w_adv;
    logic                        w_tok [SLOTS+1];
    ptts_pkg::t_pkt              w_pkt [SLOTS+1];
    ptts_pkg::t_cell_evt         w_evt [SLOTS];
    logic [ptts_pkg::ID_W-1:0]   w_slot_id [SLOTS];
    logic                        w_push_any;
    logic [SW-1:0]               w_push_idx;
    logic                        w_disp_any;
    logic [ptts_pkg::ID_W-1:0]   w_disp_id;
    logic                        w_ring_pop;
    ptts_pkg::t_ring_stat        w_ring_stat;
    logic [SW-1:0]               w_rd_slot;
    logic                        w_disp_now;
    logic [ptts_pkg::ID_W-1:0]   w_disp_now_id;

    // Move the chain only when a result can be placed in the output register
    assign w_adv = !r_out_valid || i_out_ready;

    // Feed the token into the first cell
    assign w_tok[0] = r_launch;
    always_comb begin
        w_pkt[0]         = '0;
        w_pkt[0].op      = r_op;
        w_pkt[0].id      = r_id;
        w_pkt[0].period  = r_period;
    end

    // Row of slot cells
    for (genvar g = 0; g < SLOTS; g++) begin : g_slot
        ptts_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_adv       (w_adv),
            .i_ring_full (w_ring_stat.full),
            .i_tok       (w_tok[g]),
            .i_pkt       (w_pkt[g]),
            .o_tok       (w_tok[g+1]),
            .o_pkt       (w_pkt[g+1]),
            .o_evt       (w_evt[g]),
            .o_id        (w_slot_id[g])
        );
    end

    // Collect events from the cell that holds the token
    always_comb begin
        w_push_any = 1'b0;
        w_push_idx = '0;
        w_disp_any = 1'b0;
        w_disp_id  = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (w_evt[i].push) begin
                w_push_any = 1'b1;
                w_push_idx = w_push_idx | SW'(i);
            end
            if (w_evt[i].disp) begin
                w_disp_any = 1'b1;
                w_disp_id  = w_disp_id | w_slot_id[i];
            end
        end
    end

    ptts_ring #(
        .DEPTH  (RING_DEPTH),
        .DATA_W (SW)
    ) u_ring (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_adv && w_push_any),
        .i_push_data (w_push_idx),
        .i_pop       (w_ring_pop),
        .o_stat      (w_ring_stat),
        .o_rd_data   (w_rd_slot)
    );

    // Sequencer: ring drain, chain walk, result framing
    always_comb begin
        n_state       = r_state;
        n_op          = r_op;
        n_id          = r_id;
        n_period      = r_period;
        n_launch      = r_launch;
        n_hold_valid  = r_hold_valid;
        n_hold_id     = r_hold_id;
        n_out_valid   = r_out_valid;
        n_out_kind    = r_out_kind;
        n_out_id      = r_out_id;
        n_out_acc     = r_out_acc;
        n_out_q       = r_out_q;
        n_out_d       = r_out_d;
        n_out_last    = r_out_last;
        w_ring_pop    = 1'b0;
        w_disp_now    = 1'b0;
        w_disp_now_id = '0;

        // drop the result once taken
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        // the first cell takes the token on an advance
        if (w_adv) begin
            n_launch = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op     = ptts_pkg::t_op'(i_mode);
                    n_id     = i_task_id;
                    n_period = i_period;
                    if ((ptts_pkg::t_op'(i_mode) == ptts_pkg::OP_PROC) &&
                        !w_ring_stat.empty) begin
                        n_state = S_POP_RD;
                    end else begin
                        n_launch = 1'b1;
                        n_state  = S_WALK;
                    end
                end
            end
            S_POP_RD: begin
                w_ring_pop = 1'b1;
                n_state    = S_POP_CHK;
            end
            S_POP_CHK: begin
                if (w_adv) begin
                    if (w_slot_id[w_rd_slot] != ptts_pkg::INACTIVE_ID) begin
                        w_disp_now    = 1'b1;
                        w_disp_now_id = w_slot_id[w_rd_slot];
                    end
                    if (!w_ring_stat.empty) begin
                        n_state = S_POP_RD;
                    end else begin
                        n_launch = 1'b1;
                        n_state  = S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (w_adv) begin
                    if (w_disp_any) begin
                        w_disp_now    = 1'b1;
                        w_disp_now_id = w_disp_id;
                    end
                    if (w_tok[SLOTS]) begin
                        n_out_valid = 1'b1;
                        n_out_kind  = ptts_pkg::KIND_IDLE;
                        n_out_id    = '0;
                        n_out_acc   = 1'b0;
                        n_out_q     = '0;
                        n_out_d     = '0;
                        n_out_last  = 1'b1;
                        unique case (r_op)
                            ptts_pkg::OP_TICK: begin
                                n_out_kind = ptts_pkg::KIND_TICK;
                                n_out_q    = w_pkt[SLOTS].queued;
                                n_out_d    = w_pkt[SLOTS].dropped;
                            end
                            ptts_pkg::OP_SCHED: begin
                                n_out_kind = ptts_pkg::KIND_SCHED;
                                n_out_acc  = w_pkt[SLOTS].found;
                            end
                            ptts_pkg::OP_DESCH: begin
                                n_out_kind = ptts_pkg::KIND_DESCH;
                            end
                            ptts_pkg::OP_PROC: begin
                                // release the held dispatch as the final one
                                if (r_hold_valid) begin
                                    n_out_kind   = ptts_pkg::KIND_DISPATCH;
                                    n_out_id     = r_hold_id;
                                    n_hold_valid = 1'b0;
                                end
                            end
                        endcase
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Hold each dispatch back one step so the final one can carry last
        if (w_disp_now) begin
            if (r_hold_valid) begin
                n_out_valid = 1'b1;
                n_out_kind  = ptts_pkg::KIND_DISPATCH;
                n_out_id    = r_hold_id;
                n_out_acc   = 1'b0;
                n_out_q     = '0;
                n_out_d     = '0;
                n_out_last  = 1'b0;
            end
            n_hold_valid = 1'b1;
            n_hold_id    = w_disp_now_id;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_launch     <= 1'b0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_launch     <= n_launch;
            r_hold_valid <= n_hold_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_id       <= n_id;
        r_period   <= n_period;
        r_hold_id  <= n_hold_id;
        r_out_kind <= n_out_kind;
        r_out_id   <= n_out_id;
        r_out_acc  <= n_out_acc;
        r_out_q    <= n_out_q;
        r_out_d    <= n_out_d;
        r_out_last <= n_out_last;
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_out_kind;
    assign o_task_id_res = r_out_id;
    assign o_accepted    = r_out_acc;
    assign o_queued      = r_out_q;
    assign o_dropped     = r_out_d;
    assign o_last        = r_out_last;

endmodule

@@ src/ptts_checker.sv @@
`include "periodic_task_tick_scheduler_assert.svh"

module ptts_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_ready,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic [ptts_pkg::KIND_W-1:0] o_kind,
    input logic [ptts_pkg::ID_W-1:0]   o_task_id_res,
    input logic                        o_last
);

    // A stalled result holds
    `PTTS_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_kind) && $stable(o_task_id_res) && $stable(o_last))

    // The block is busy in the cycle after it takes a transaction
    `PTTS_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready)

    // Only the final result of a transaction may wait while a new one is open
    `PTTS_ASSERT_IMPL(a_ready_only_last, o_in_ready && o_out_valid, o_last)

    // Nothing to run is always a single, final result without an id
    `PTTS_ASSERT_IMPL(a_idle_final, o_out_valid && (o_kind == ptts_pkg::KIND_IDLE),
        o_last && (o_task_id_res == '0))

endmodule

bind periodic_task_tick_scheduler ptts_checker u_ptts_checker (.*);

@@ tb/periodic_task_tick_scheduler_test.sv @@
// One result as it leaves the scheduler
typedef struct packed {
    ptts_pkg::t_kind             kind;
    logic [ptts_pkg::ID_W-1:0]   task_id;
    logic                        accepted;
    logic [ptts_pkg::CNT_W-1:0]  queued;
    logic [ptts_pkg::CNT_W-1:0]  dropped;
    logic                        last;
} t_sched_result;

localparam int TB_SLOTS    = 8;
localparam int TB_RING_LEN = 16;

// Shadow of the slot table and due ring, plus the results still owed by the block
class sched_scoreboard;
    logic [ptts_pkg::ID_W-1:0]  slot_id  [TB_SLOTS];
    logic [ptts_pkg::PER_W-1:0] slot_per [TB_SLOTS];
    logic [ptts_pkg::PER_W-1:0] slot_cnt [TB_SLOTS];
    int unsigned                due_slot [TB_RING_LEN];
    int unsigned                due_head;
    int unsigned                due_count;
    t_sched_result              owed[$];
    int unsigned                mismatches;
    int unsigned                checked;
    int unsigned                dispatched;
    int unsigned                lost_to_full_ring;
    int unsigned                op_seen [4];

    function new();
        for (int i = 0; i < TB_SLOTS; i++) begin
            slot_id[i]  = ptts_pkg::INACTIVE_ID;
            slot_per[i] = '0;
            slot_cnt[i] = '0;
        end
        for (int i = 0; i < TB_RING_LEN; i++) begin
            due_slot[i] = 0;
        end
        for (int i = 0; i < 4; i++) begin
            op_seen[i] = 0;
        end
        due_head          = 0;
        due_count         = 0;
        mismatches        = 0;
        checked           = 0;
        dispatched        = 0;
        lost_to_full_ring = 0;
    endfunction

    function t_sched_result make_result(ptts_pkg::t_kind kind,
                                        logic [ptts_pkg::ID_W-1:0] id,
                                        logic acc,
                                        logic [ptts_pkg::CNT_W-1:0] q,
                                        logic [ptts_pkg::CNT_W-1:0] d,
                                        logic last);
        t_sched_result r;
        r.kind     = kind;
        r.task_id  = id;
        r.accepted = acc;
        r.queued   = q;
        r.dropped  = d;
        r.last     = last;
        return r;
    endfunction

    function string show(t_sched_result r);
        return $sformatf("kind=%0d id=%0d acc=%0d queued=%0d dropped=%0d last=%0d",
                         r.kind, r.task_id, r.accepted, r.queued, r.dropped, r.last);
    endfunction

    // Update the shadow state for one accepted transaction and queue its results
    function void note_input(ptts_pkg::t_op op, logic [ptts_pkg::ID_W-1:0] id,
                             logic [ptts_pkg::PER_W-1:0] per);
        t_sched_result              runs[$];
        logic [ptts_pkg::CNT_W-1:0] q;
        logic [ptts_pkg::CNT_W-1:0] d;
        logic                       acc;
        int unsigned                s;
        q   = '0;
        d   = '0;
        acc = 1'b0;
        op_seen[op]++;
        case (op)
            ptts_pkg::OP_TICK: begin
                // Walk periodic slots in order; due ones go on the ring or are lost
                for (int i = 0; i < TB_SLOTS; i++) begin
                    if (slot_id[i] != ptts_pkg::INACTIVE_ID && slot_per[i] != '0) begin
                        if (slot_cnt[i] == slot_per[i]) begin
                            if (due_count < TB_RING_LEN) begin
                                due_slot[(due_head + due_count) % TB_RING_LEN] = i;
                                due_count++;
                                q = q + 1'b1;
                            end else begin
                                d = d + 1'b1;
                            end
                            slot_cnt[i] = 16'd1;
                        end else begin
                            slot_cnt[i] = slot_cnt[i] + 16'd1;
                        end
                    end
                end
                lost_to_full_ring += d;
                owed.push_back(make_result(ptts_pkg::KIND_TICK, '0, 1'b0, q, d, 1'b1));
            end
            ptts_pkg::OP_SCHED: begin
                // Take the lowest free slot unless the id is the reserved one
                if (id != ptts_pkg::INACTIVE_ID) begin
                    for (int i = 0; i < TB_SLOTS; i++) begin
                        if (!acc && slot_id[i] == ptts_pkg::INACTIVE_ID) begin
                            slot_id[i]  = id;
                            slot_per[i] = per;
                            slot_cnt[i] = 16'd1;
                            acc         = 1'b1;
                        end
                    end
                end
                owed.push_back(make_result(ptts_pkg::KIND_SCHED, '0, acc, '0, '0, 1'b1));
            end
            ptts_pkg::OP_DESCH: begin
                if (id != ptts_pkg::INACTIVE_ID) begin
                    for (int i = 0; i < TB_SLOTS; i++) begin
                        if (slot_id[i] == id) slot_id[i] = ptts_pkg::INACTIVE_ID;
                    end
                end
                owed.push_back(make_result(ptts_pkg::KIND_DESCH, '0, 1'b0, '0, '0, 1'b1));
            end
            default: begin
                // Drain the ring, skipping slots freed since they were queued
                while (due_count != 0) begin
                    s         = due_slot[due_head];
                    due_head  = (due_head + 1) % TB_RING_LEN;
                    due_count--;
                    if (slot_id[s] != ptts_pkg::INACTIVE_ID)
                        runs.push_back(make_result(ptts_pkg::KIND_DISPATCH, slot_id[s],
                                                   1'b0, '0, '0, 1'b0));
                end
                // Then every immediate task in slot order
                for (int i = 0; i < TB_SLOTS; i++) begin
                    if (slot_id[i] != ptts_pkg::INACTIVE_ID && slot_per[i] == '0)
                        runs.push_back(make_result(ptts_pkg::KIND_DISPATCH, slot_id[i],
                                                   1'b0, '0, '0, 1'b0));
                end
                dispatched += runs.size();
                if (runs.size() == 0)
                    runs.push_back(make_result(ptts_pkg::KIND_IDLE, '0, 1'b0, '0, '0, 1'b1));
                else
                    runs[runs.size() - 1].last = 1'b1;
                foreach (runs[k]) owed.push_back(runs[k]);
            end
        endcase
    endfunction

    function void note_mismatch(string msg);
        mismatches++;
        if (mismatches <= 10) $display("MISMATCH %s", msg);
    endfunction

    // Compare one output transaction with the oldest owed result
    function void check_result(t_sched_result got);
        t_sched_result want;
        checked++;
        if (owed.size() == 0) begin
            note_mismatch($sformatf("result %0d with nothing owed: %s", checked, show(got)));
            return;
        end
        want = owed.pop_front();
        if (got.kind !== want.kind || got.task_id !== want.task_id
                || got.accepted !== want.accepted || got.queued !== want.queued
                || got.dropped !== want.dropped || got.last !== want.last)
            note_mismatch($sformatf("result %0d: want %s / got %s",
                                    checked, show(want), show(got)));
    endfunction
endclass

module periodic_task_tick_scheduler_test;
    import ptts_pkg::*;

    localparam int RANDOM_ITEMS = 400;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [1:0]           i_mode;
    logic [ID_W-1:0]      i_task_id;
    logic [PER_W-1:0]     i_period;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [KIND_W-1:0]    o_kind;
    logic [ID_W-1:0]      o_task_id_res;
    logic                 o_accepted;
    logic [CNT_W-1:0]     o_queued;
    logic [CNT_W-1:0]     o_dropped;
    logic                 o_last;

    sched_scoreboard      sb;
    bit                   rx_steady = 1'b0;
    bit                   rx_stall  = 1'b0;
    int unsigned          rx_left   = 0;

    periodic_task_tick_scheduler u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_mode        (i_mode),
        .i_task_id     (i_task_id),
        .i_period      (i_period),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_kind        (o_kind),
        .o_task_id_res (o_task_id_res),
        .o_accepted    (o_accepted),
        .o_queued      (o_queued),
        .o_dropped     (o_dropped),
        .o_last        (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver: alternate ready and stall runs of random length
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_stall = !rx_steady && ($urandom_range(0, 2) == 0);
            rx_left  = rx_stall ? $urandom_range(1, 8) : $urandom_range(1, 12);
        end
        rx_left--;
        i_out_ready <= !rx_stall;
    end

    // Sample both handshakes on the edge, input side first
    always @(posedge i_clk) begin : monitor_blk
        t_sched_result seen;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                sb.note_input(t_op'(i_mode), i_task_id, i_period);
            if (o_out_valid && i_out_ready) begin
                seen.kind     = t_kind'(o_kind);
                seen.task_id  = o_task_id_res;
                seen.accepted = o_accepted;
                seen.queued   = o_queued;
                seen.dropped  = o_dropped;
                seen.last     = o_last;
                sb.check_result(seen);
            end
        end
    end

    // Present one transaction and hold it until the block takes it
    task automatic send_item(input t_op op, input logic [ID_W-1:0] id,
                             input logic [PER_W-1:0] per);
        i_in_valid <= 1'b1;
        i_mode     <= op;
        i_task_id  <= id;
        i_period   <= per;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic pause_input(input int unsigned cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Random mix weighted toward ticks and small periods so the ring fills and drains
    task automatic send_random_item();
        int unsigned      pick;
        t_op              op;
        logic [ID_W-1:0]  id;
        logic [PER_W-1:0] per;
        pick = $urandom_range(0, 99);
        if (pick < 38)      op = OP_TICK;
        else if (pick < 60) op = OP_SCHED;
        else if (pick < 75) op = OP_DESCH;
        else                op = OP_PROC;
        // Draw ids mostly from a small pool so deschedules hit live tasks
        pick = $urandom_range(0, 19);
        if (pick == 0)     id = INACTIVE_ID;
        else if (pick < 5) id = ID_W'($urandom_range(0, 254));
        else               id = ID_W'($urandom_range(10, 17));
        pick = $urandom_range(0, 19);
        if (pick < 3)       per = '0;
        else if (pick < 17) per = PER_W'($urandom_range(1, 4));
        else                per = PER_W'($urandom);
        send_item(op, id, per);
    endtask

    initial begin
        int unsigned burst_left;
        bit          tx_steady;
        sb          = new();
        burst_left  = 0;
        tx_steady   = 1'b0;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_mode      <= OP_TICK;
        i_task_id   <= '0;
        i_period    <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty table: nothing to run, reserved id ignored or rejected
        send_item(OP_PROC, 8'd0, 16'd0);
        send_item(OP_DESCH, INACTIVE_ID, 16'd0);
        send_item(OP_SCHED, INACTIVE_ID, 16'd7);
        // Fill the table: one immediate, one longest period, six due every tick
        send_item(OP_SCHED, 8'd0, 16'd0);
        send_item(OP_SCHED, 8'd254, 16'hFFFF);
        for (int i = 1; i <= 6; i++) send_item(OP_SCHED, ID_W'(i), 16'd1);
        send_item(OP_SCHED, 8'd9, 16'd3);
        // Three ticks overflow the ring on the last one
        repeat (3) send_item(OP_TICK, 8'd0, 16'd0);
        // Free two queued slots and reuse one of them before the drain
        send_item(OP_DESCH, 8'd3, 16'd0);
        send_item(OP_DESCH, 8'd4, 16'd0);
        send_item(OP_SCHED, 8'd200, 16'd2);
        send_item(OP_PROC, 8'd0, 16'd0);
        // Same id twice, then one deschedule clears both
        send_item(OP_SCHED, 8'd200, 16'd0);
        send_item(OP_DESCH, 8'd200, 16'd0);
        send_item(OP_DESCH, 8'd0, 16'd0);
        send_item(OP_PROC, 8'hAA, 16'h5555);
        send_item(OP_TICK, 8'd55, 16'hAAAA);
        send_item(OP_TICK, 8'd0, 16'd0);
        send_item(OP_PROC, 8'd0, 16'd0);

        // Random traffic in bursts, with steady stretches on either side
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) begin
                tx_steady = ($urandom_range(0, 2) == 0);
                rx_steady = ($urandom_range(0, 2) == 0);
            end
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 16);
                if (!tx_steady) pause_input($urandom_range(1, 6));
            end
            burst_left--;
            send_random_item();
        end
        i_in_valid <= 1'b0;

        // Drain, then watch for stray results
        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        $display("covered %0d ticks, %0d schedules, %0d deschedules, %0d process requests",
                 sb.op_seen[OP_TICK], sb.op_seen[OP_SCHED], sb.op_seen[OP_DESCH],
                 sb.op_seen[OP_PROC]);
        $display("checked %0d results: %0d dispatches, %0d due slots lost to a full ring, %0d bad",
                 sb.checked, sb.dispatched, sb.lost_to_full_ring, sb.mismatches);
        if (sb.mismatches == 0 && sb.owed.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #5000000;
        $display("timeout with %0d results still owed", sb.owed.size());
        $display("== FAIL ==");
        $finish;
    end
endmodule
